/* src/hidkbd_pkg.sv */
package hidkbd_pkg;

  // queue size used when the top level is not told otherwise
  localparam int QUEUE_DEPTH_DEF = 32;

  localparam int NUM_KEYS     = 6;
  localparam int KEY_IDX_W    = $clog2(NUM_KEYS);
  localparam int NUM_MOD_BITS = 8;
  localparam int COUNT_W      = 5;
  localparam int LEVEL_W      = 5;

  // usage code of modifier bit 0
  localparam logic [7:0] MOD_BASE = 8'hE0;

  // diff sweep: modifier bits, then releases of old keys, then presses of new keys
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] REL_BASE  = STEP_W'(NUM_MOD_BITS);
  localparam logic [STEP_W-1:0] PRS_BASE  = STEP_W'(NUM_MOD_BITS + NUM_KEYS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_MOD_BITS + 2 * NUM_KEYS - 1);

  typedef logic [NUM_KEYS-1:0][7:0] key_set_t;

  typedef enum logic [1:0] {
    CMD_REPORT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIFF,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              do_step;
    logic [STEP_W-1:0] step;
    logic              commit;
    logic              clear_prev;
    logic              pop;
    logic              load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

/* src/hid_keyboard_report_to_key_events.sv */
// channel   signals                                           direction
// request   in_valid, in_stall, cmd, new_modifier, new_key0-5  in (in_stall out)
// result    out_valid, out_stall, event_valid, event_pressed,  out (out_stall in)
//           event_code, events_added, events_dropped, queue_level
//
// one request at a time; a report is accepted in ST_IDLE, then walks the diff steps in ST_DIFF
// (20 diff steps: 8 modifier bits, 6 releases, 6 presses), then loads its result in ST_REPLY
// pop, clear and no-op go from ST_IDLE straight to ST_REPLY, which loads the result register
// synchronous reset clears the previous report and empties the queue; in_stall is high during it
// a result held by out_stall keeps the next request waiting once its result is ready
module hid_keyboard_report_to_key_events #(
  parameter int QUEUE_DEPTH = hidkbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic [7:0]                     new_modifier,
  input  logic [7:0]                     new_key0,
  input  logic [7:0]                     new_key1,
  input  logic [7:0]                     new_key2,
  input  logic [7:0]                     new_key3,
  input  logic [7:0]                     new_key4,
  input  logic [7:0]                     new_key5,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           event_valid,
  output logic                           event_pressed,
  output logic [7:0]                     event_code,
  output logic [hidkbd_pkg::COUNT_W-1:0] events_added,
  output logic [hidkbd_pkg::COUNT_W-1:0] events_dropped,
  output logic [hidkbd_pkg::LEVEL_W-1:0] queue_level
);

  hidkbd_pkg::ctrl_cmd_t  ctrl;
  hidkbd_pkg::dp_status_t status;
  hidkbd_pkg::key_set_t   new_keys;
  hidkbd_pkg::cmd_t       cmd_in;

  // decode of the request command, shared by controller and datapath
  assign cmd_in = hidkbd_pkg::cmd_t'(cmd);

  // slot 0 sits in the lowest byte so slot order follows the index
  assign new_keys = {new_key5, new_key4, new_key3, new_key2, new_key1, new_key0};

  // sequencer: accepts requests and walks the diff steps
  hidkbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd_in),
    .status   (status),
    .in_stall (in_stall),
    .ctrl     (ctrl)
  );

  // previous report, event queue and result register
  hidkbd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .cmd            (cmd_in),
    .new_modifier   (new_modifier),
    .new_keys       (new_keys),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .event_valid    (event_valid),
    .event_pressed  (event_pressed),
    .event_code     (event_code),
    .events_added   (events_added),
    .events_dropped (events_dropped),
    .queue_level    (queue_level)
  );

endmodule

/* src/hidkbd_ctrl.sv */
module hidkbd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  hidkbd_pkg::cmd_t       cmd,
  input  hidkbd_pkg::dp_status_t status,
  output logic                   in_stall,
  output hidkbd_pkg::ctrl_cmd_t  ctrl
);

  hidkbd_pkg::state_t state, state_next;
  logic [hidkbd_pkg::STEP_W-1:0] step, step_next;
  logic accept;

  // no request is taken while reset is applied
  assign accept = in_valid && !rst && (state == hidkbd_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hidkbd_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      hidkbd_pkg::ST_IDLE: begin
        step_next = '0;
        if (accept) begin
          if (cmd == hidkbd_pkg::CMD_REPORT) begin
            state_next = hidkbd_pkg::ST_DIFF;
          end else begin
            state_next = hidkbd_pkg::ST_REPLY;
          end
        end
      end
      hidkbd_pkg::ST_DIFF: begin
        step_next = step + 1'b1;
        if (step == hidkbd_pkg::LAST_STEP) begin
          state_next = hidkbd_pkg::ST_REPLY;
        end
      end
      hidkbd_pkg::ST_REPLY: begin
        if (!status.out_busy) begin
          state_next = hidkbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hidkbd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall        = rst || (state != hidkbd_pkg::ST_IDLE);
    ctrl            = '0;
    ctrl.step       = step;
    ctrl.accept     = accept;
    ctrl.clear_prev = accept && (cmd == hidkbd_pkg::CMD_CLEAR);
    ctrl.pop        = accept && (cmd == hidkbd_pkg::CMD_POP);
    ctrl.do_step    = (state == hidkbd_pkg::ST_DIFF);
    ctrl.commit     = (state == hidkbd_pkg::ST_DIFF) && (step == hidkbd_pkg::LAST_STEP);
    ctrl.load       = (state == hidkbd_pkg::ST_REPLY) && !status.out_busy;
  end

endmodule

/* src/hidkbd_dp.sv */
module hidkbd_dp #(
  parameter int QUEUE_DEPTH = hidkbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hidkbd_pkg::ctrl_cmd_t               ctrl,
  output hidkbd_pkg::dp_status_t              status,
  input  hidkbd_pkg::cmd_t                    cmd,
  input  logic [7:0]                          new_modifier,
  input  hidkbd_pkg::key_set_t                new_keys,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                event_valid,
  output logic                                event_pressed,
  output logic [7:0]                          event_code,
  output logic [hidkbd_pkg::COUNT_W-1:0]      events_added,
  output logic [hidkbd_pkg::COUNT_W-1:0]      events_dropped,
  output logic [hidkbd_pkg::LEVEL_W-1:0]      queue_level
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int LVL_W = (PTR_W > hidkbd_pkg::LEVEL_W) ? PTR_W : hidkbd_pkg::LEVEL_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  hidkbd_pkg::cmd_t     cmd_q;
  logic [7:0]           mod_q;
  hidkbd_pkg::key_set_t keys_q;
  logic [7:0]           prev_modifier;
  hidkbd_pkg::key_set_t prev_keys;

  logic [8:0]       event_store [QUEUE_DEPTH];
  logic [PTR_W-1:0] write_ptr, read_ptr;
  logic [8:0]       rd_data;
  logic             rd_hit;

  logic [hidkbd_pkg::COUNT_W-1:0] added_cnt, dropped_cnt;

  logic [2:0]                       mod_idx;
  logic [hidkbd_pkg::KEY_IDX_W-1:0] key_idx;
  logic [7:0]                       key_sel;
  logic                             cand_valid;
  logic                             cand_pressed;
  logic [7:0]                       cand_code;
  logic [PTR_W-1:0]                 wp_inc, rp_inc;
  logic                             full;
  logic                             do_write;
  logic [LVL_W-1:0]                 level;

  function automatic logic has_code(hidkbd_pkg::key_set_t keys, logic [7:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < hidkbd_pkg::NUM_KEYS; i++) begin
      hit = hit | (keys[i] == code);
    end
    return hit;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign wp_inc = ptr_inc(write_ptr);
  assign rp_inc = ptr_inc(read_ptr);
  assign full   = (wp_inc == read_ptr);

  // one candidate event per diff step
  always_comb begin
    mod_idx      = ctrl.step[2:0];
    key_idx      = '0;
    key_sel      = '0;
    cand_valid   = 1'b0;
    cand_pressed = 1'b0;
    cand_code    = hidkbd_pkg::MOD_BASE | {5'd0, mod_idx};
    priority if (ctrl.step < hidkbd_pkg::REL_BASE) begin
      cand_valid   = prev_modifier[mod_idx] ^ mod_q[mod_idx];
      cand_pressed = mod_q[mod_idx];
    end else if (ctrl.step < hidkbd_pkg::PRS_BASE) begin
      key_idx    = hidkbd_pkg::KEY_IDX_W'(ctrl.step - hidkbd_pkg::REL_BASE);
      key_sel    = prev_keys[key_idx];
      cand_code  = key_sel;
      cand_valid = (key_sel != 8'd0) && !has_code(keys_q, key_sel);
    end else begin
      key_idx      = hidkbd_pkg::KEY_IDX_W'(ctrl.step - hidkbd_pkg::PRS_BASE);
      key_sel      = keys_q[key_idx];
      cand_code    = key_sel;
      cand_pressed = 1'b1;
      cand_valid   = (key_sel != 8'd0) && !has_code(prev_keys, key_sel);
    end
  end

  assign do_write = ctrl.do_step && cand_valid && !full;

  always_comb begin
    if (write_ptr >= read_ptr) begin
      level = LVL_W'(write_ptr) - LVL_W'(read_ptr);
    end else begin
      level = LVL_W'(write_ptr) + LVL_W'(QUEUE_DEPTH) - LVL_W'(read_ptr);
    end
  end

  // request capture and previous report
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_q  <= cmd;
      mod_q  <= new_modifier;
      keys_q <= new_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_modifier <= '0;
      prev_keys     <= '0;
    end else if (ctrl.clear_prev) begin
      prev_modifier <= '0;
      prev_keys     <= '0;
    end else if (ctrl.commit) begin
      prev_modifier <= mod_q;
      prev_keys     <= keys_q;
    end
  end

  // event queue
  always_ff @(posedge clk) begin
    if (do_write) begin
      event_store[write_ptr] <= {cand_pressed, cand_code};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      rd_data <= event_store[read_ptr];
      rd_hit  <= (write_ptr != read_ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
    end else begin
      if (do_write) begin
        write_ptr <= wp_inc;
      end
      if (ctrl.pop && (write_ptr != read_ptr)) begin
        read_ptr <= rp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      added_cnt   <= '0;
      dropped_cnt <= '0;
    end else if (ctrl.do_step && cand_valid) begin
      if (full) begin
        dropped_cnt <= dropped_cnt + 1'b1;
      end else begin
        added_cnt <= added_cnt + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      event_valid    <= 1'b0;
      event_pressed  <= 1'b0;
      event_code     <= '0;
      events_added   <= '0;
      events_dropped <= '0;
      queue_level    <= level[hidkbd_pkg::LEVEL_W-1:0];
      if ((cmd_q == hidkbd_pkg::CMD_POP) && rd_hit) begin
        event_valid   <= 1'b1;
        event_pressed <= rd_data[8];
        event_code    <= rd_data[7:0];
      end
      if (cmd_q == hidkbd_pkg::CMD_REPORT) begin
        events_added   <= added_cnt;
        events_dropped <= dropped_cnt;
      end
    end
  end

  assign status.out_busy = out_valid && out_stall;

endmodule
